// ----- src/skt_pkg.sv -----
// ----------------------------------------------------------------------------
// skt_pkg
// shared types, widths and codes of the sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int DEPTH = 64;
  localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCW   = $clog2(DEPTH + 1);
  localparam int KW    = 27;
  localparam int GW    = 10;
  localparam int PW    = 7;
  localparam int CMPW  = (OCW > PW) ? OCW : PW;

  // operation codes
  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REPK   = 3'd1;
  localparam logic [2:0] OP_REPP   = 3'd2;
  localparam logic [2:0] OP_LOOKK  = 3'd3;
  localparam logic [2:0] OP_LOOKP  = 3'd4;
  localparam logic [2:0] OP_DELETE = 3'd5;
  localparam logic [2:0] OP_MAX    = 3'd6;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_BADPOS  = 3'd2;
  localparam logic [2:0] ST_ABSENT  = 3'd3;
  localparam logic [2:0] ST_NOGRADE = 3'd4;

  typedef struct packed {
    logic [KW-1:0] key;
    logic          graded;
    logic [GW-1:0] grade;
  } rec_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SDEC,
    S_SRCH,
    S_SCAN,
    S_WRITE,
    S_READ
  } state_e;

endpackage

// ----- src/skt_cell.sv -----
// ----------------------------------------------------------------------------
// skt_cell
// one record slot of the rotating table ring
// ----------------------------------------------------------------------------
module skt_cell (
  input  logic          clk_i,
  input  logic          shift_i,
  input  skt_pkg::rec_t rec_i,
  output skt_pkg::rec_t rec_o
);
  import skt_pkg::*;

  rec_t rec_q;

  // takes the record of the next cell up whenever the ring turns
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      rec_q <= rec_i;
    end
  end

  assign rec_o = rec_q;

endmodule

// ----- src/sorted_key_table_with_max_core.sv -----
// ----------------------------------------------------------------------------
// sorted_key_table_with_max_core
// sorted record table with key search, insert, delete and best-grade query
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one operation per item: tuser holds the opcode, tdata the
//   key, position, grade flag and grade. m_axis returns exactly one result
//   item per operation: tuser holds the status, tdata the returned record and
//   the record count after the operation.
//   the records sit in a ring of DEPTH cells that turns one cell per cycle
//   outside the idle and decision states; the cell at the head is the one
//   examined, so every visit of the table is a full turn of the ring.
//   steps from acceptance to result valid:
//     max query, opcode 7 and rejected operations: decided at acceptance
//     lookup by position, positional replace: one turn
//     insert: two turns (one to find the slot, one to write)
//     key operations: one turn per binary search probe, each followed by
//     a decision step, up to log2(DEPTH)+1 probes, plus one write turn for
//     replace and delete
//   the best graded record is rebuilt during every write turn, so a max query
//   needs no turn. one item is in work at a time; a new item is taken only
//   once the previous result has left the output register.
//   reset empties the table and drops the best record; cell contents are not
//   cleared. a stalled receiver holds the result and blocks new input items.
// ----------------------------------------------------------------------------
module sorted_key_table_with_max_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // record_key, position, carries_grade, grade_value
  input  logic [2:0]  s_axis_tuser,  // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // found_key, found_has_grade, found_grade, entry_count
  output logic [2:0]  m_axis_tuser   // status
);
  import skt_pkg::*;

  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);

  // input fields
  logic [KW-1:0] in_key;
  logic [PW-1:0] in_pos;
  logic          in_cg;
  logic [GW-1:0] in_grade;
  logic          accept;

  assign in_key   = s_axis_tdata[KW-1:0];
  assign in_pos   = s_axis_tdata[KW+PW-1:KW];
  assign in_cg    = s_axis_tdata[KW+PW];
  assign in_grade = s_axis_tdata[KW+PW+GW:KW+PW+1];
  assign accept   = s_axis_tvalid && s_axis_tready;

  state_e state_q, state_d;

  logic [2:0]     op_q;
  rec_t           new_q;        // record carried by the operation
  logic [IW-1:0]  t_q;          // position now at the ring head
  logic [IW-1:0]  widx_q;       // target position (search hit, insert slot)
  logic [OCW-1:0] occ_q;
  logic [OCW-1:0] lo_q, hip_q;  // search window, upper bound exclusive
  logic           found_q;
  rec_t           fnd_q;
  rec_t           carry_q;
  logic           bv_q;
  rec_t           best_q;

  // result register
  logic           ovalid_q;
  logic [2:0]     ostat_q;
  rec_t           orec_q;
  logic [OCW-1:0] ocnt_q;

  // ring of cells
  rec_t cell_out [DEPTH];
  rec_t emit;
  logic shift;
  rec_t head, head_nx;

  assign head    = cell_out[0];
  assign head_nx = cell_out[1];

  for (genvar i = 0; i < DEPTH; i++) begin : g_ring
    rec_t nxt;
    if (i == DEPTH - 1) begin : g_tail
      assign nxt = emit;
    end else begin : g_body
      assign nxt = cell_out[i+1];
    end
    skt_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .rec_i  (nxt),
      .rec_o  (cell_out[i])
    );
  end

  // position checks on the incoming item and at the ring head
  logic pos_bad;
  assign pos_bad = (CMPW'(in_pos) < CMPW'(1)) || (CMPW'(in_pos) > CMPW'(occ_q));

  logic in_range;
  assign in_range = {1'b0, t_q} < occ_q;

  // search probe
  logic [IW-1:0]  mid;
  logic [OCW:0]   mid_sum;
  logic           at_mid;
  assign mid_sum = (OCW + 1)'(lo_q) + (OCW + 1)'(hip_q) - (OCW + 1)'(1);
  assign mid     = IW'(mid_sum >> 1);
  assign at_mid  = (t_q == widx_q);

  logic pass_end;
  assign pass_end = (t_q == LAST);

  // what goes back into the tail of the ring
  always_comb begin
    emit = head;
    if (state_q == S_WRITE) begin
      case (op_q)
        OP_INSERT: begin
          if (t_q < widx_q)       emit = head;
          else if (t_q == widx_q) emit = new_q;
          else                    emit = carry_q;
        end
        OP_REPK, OP_REPP: begin
          if (t_q == widx_q) emit = new_q;
        end
        OP_DELETE: begin
          if (t_q >= widx_q) emit = head_nx;
        end
        default: emit = head;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            OP_INSERT:                   state_d = (occ_q >= OCW'(DEPTH)) ? S_IDLE : S_SCAN;
            OP_REPK, OP_LOOKK, OP_DELETE: state_d = S_SDEC;
            OP_REPP:                     state_d = pos_bad ? S_IDLE : S_WRITE;
            OP_LOOKP:                    state_d = pos_bad ? S_IDLE : S_READ;
            default:                     state_d = S_IDLE;
          endcase
        end
      end
      S_SDEC: begin
        if (found_q) begin
          state_d = (op_q == OP_LOOKK) ? S_IDLE : S_WRITE;
        end else if (lo_q < hip_q) begin
          state_d = S_SRCH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_SRCH:  if (pass_end) state_d = S_SDEC;
      S_SCAN:  if (pass_end) state_d = S_WRITE;
      S_WRITE: if (pass_end) state_d = S_IDLE;
      S_READ:  if (pass_end) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = (state_q == S_IDLE) && !ovalid_q;
    shift = (state_q == S_SRCH) || (state_q == S_SCAN) ||
            (state_q == S_WRITE) || (state_q == S_READ);
  end

  // result of the finishing cycle
  logic       fin;
  logic [2:0] fstat;
  rec_t       frec;
  always_comb begin
    fin   = 1'b0;
    fstat = ST_OK;
    frec  = '0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (s_axis_tuser)
            OP_INSERT: begin
              fin   = (occ_q >= OCW'(DEPTH));
              fstat = ST_FULL;
            end
            OP_REPP, OP_LOOKP: begin
              fin   = pos_bad;
              fstat = ST_BADPOS;
            end
            OP_MAX: begin
              fin   = 1'b1;
              fstat = bv_q ? ST_OK : ST_NOGRADE;
              frec  = bv_q ? best_q : '0;
            end
            OP_REPK, OP_LOOKK, OP_DELETE: fin = 1'b0;
            default: fin = 1'b1;
          endcase
        end
      end
      S_SDEC: begin
        if (found_q) begin
          fin  = (op_q == OP_LOOKK);
          frec = fnd_q;
        end else if (!(lo_q < hip_q)) begin
          fin   = 1'b1;
          fstat = ST_ABSENT;
        end
      end
      S_WRITE: fin = pass_end;
      S_READ: begin
        fin  = pass_end;
        // the last position reaches the head in the finishing cycle
        frec = at_mid ? head : fnd_q;
      end
      default: fin = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      occ_q    <= '0;
      bv_q     <= 1'b0;
      ovalid_q <= 1'b0;
      t_q      <= '0;
      found_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (shift) t_q <= t_q + IW'(1);

      if (fin)                ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;

      if (state_q == S_IDLE && accept) begin
        found_q <= 1'b0;
        if (s_axis_tuser == OP_REPP && !pos_bad) begin
          bv_q <= 1'b0;
        end
      end
      if (state_q == S_SRCH && at_mid && head.key == new_q.key) found_q <= 1'b1;

      if (state_q == S_SDEC && found_q && op_q != OP_LOOKK) bv_q <= 1'b0;
      if (state_q == S_SCAN && pass_end) begin
        occ_q <= occ_q + OCW'(1);
        bv_q  <= 1'b0;
      end
      if (state_q == S_SDEC && found_q && op_q == OP_DELETE) occ_q <= occ_q - OCW'(1);

      // best record rebuilt from the stream written back
      if (state_q == S_WRITE && in_range && emit.graded &&
          (!bv_q || emit.grade > best_q.grade)) begin
        bv_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    carry_q <= head;
    if (state_q == S_IDLE && accept) begin
      op_q         <= s_axis_tuser;
      new_q.key    <= in_key;
      new_q.graded <= in_cg;
      new_q.grade  <= in_cg ? in_grade : '0;
      lo_q         <= '0;
      hip_q        <= occ_q;
      widx_q       <= (s_axis_tuser == OP_INSERT) ? '0 : IW'(in_pos - PW'(1));
    end
    if (state_q == S_SDEC && !found_q && lo_q < hip_q) widx_q <= mid;
    if (state_q == S_SRCH && at_mid) begin
      fnd_q <= head;
      if (new_q.key < head.key)      hip_q <= OCW'(widx_q);
      else if (new_q.key > head.key) lo_q  <= OCW'(widx_q) + OCW'(1);
    end
    if (state_q == S_READ && at_mid) fnd_q <= head;
    if (state_q == S_SCAN && in_range && new_q.key > head.key) widx_q <= t_q + IW'(1);
    if (state_q == S_WRITE && in_range && emit.graded &&
        (!bv_q || emit.grade > best_q.grade)) begin
      best_q <= emit;
    end
    if (fin) begin
      ostat_q <= fstat;
      orec_q  <= frec;
      ocnt_q  <= occ_q;
    end
  end

  // the count seen at the finish of an insert or delete write turn is final,
  // because occ_q was updated before the write turn began
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = ostat_q;
  assign m_axis_tdata  = {3'b000, PW'(ocnt_q), orec_q.grade, orec_q.graded, orec_q.key};

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCW'(DEPTH)) else $error("record count beyond depth");

  a_no_take_while_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !ovalid_q) else $error("input taken with result pending");

  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE && pass_end) |=> (ovalid_q && state_q == S_IDLE))
    else $error("write turn ended without result");

  a_turn_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (t_q == '0)) else $error("ring left out of alignment");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sorted key table with best-grade query
// ----------------------------------------------------------------------------
// drives operations on the input stream with random gaps and stalls the
// result stream at random. a behavioral table inside the bench predicts
// each result as its item is accepted. every result is checked field by
// field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import skt_pkg::*;

  localparam logic [2:0] OP_NOP    = 3'd7;  // unused opcode
  localparam int         LIMIT     = 3000000;
  localparam int         N_RANDOM  = 1060;

  typedef struct packed {
    logic [2:0]    status;
    logic [KW-1:0] key;
    logic          graded;
    logic [GW-1:0] grade;
    logic [6:0]    count;
  } answer_t;

  logic        clk_i, rst_ni;
  logic        s_axis_tvalid, s_axis_tready;
  logic [47:0] s_axis_tdata;  // record_key, position, carries_grade, grade_value
  logic [2:0]  s_axis_tuser;  // opcode
  logic        m_axis_tvalid, m_axis_tready;
  logic [47:0] m_axis_tdata;  // found_key, found_has_grade, found_grade, entry_count
  logic [2:0]  m_axis_tuser;  // status

  sorted_key_table_with_max_core dut (.*);

  // behavioral copy of the table
  logic [KW-1:0] tbl_key   [DEPTH];
  logic [GW-1:0] tbl_grade [DEPTH];
  logic          tbl_graded[DEPTH];
  int            tbl_count;

  answer_t pending_answers[$];
  int      mismatches;
  int      cycles;
  bit      drain_rx_stalls;  // stretch with no receiver stalls
  bit      quiet_tx;         // stretch with no sender gaps
  bit      rx_took;
  int      rx_wait;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[sorted_key_table_with_max_core] ERROR");
      $finish;
    end
  end

  // binary search as the block does it: first equal probe wins
  function automatic int search_key(logic [KW-1:0] k);
    int lo, hi, mid;
    lo = 0;
    hi = tbl_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (k < tbl_key[mid]) hi = mid - 1;
      else if (k > tbl_key[mid]) lo = mid + 1;
      else return mid;
    end
    return -1;
  endfunction

  function automatic void store_rec(int i, logic [KW-1:0] k, logic g, logic [GW-1:0] gr);
    tbl_key[i]    = k;
    tbl_graded[i] = g;
    tbl_grade[i]  = g ? gr : '0;
  endfunction

  // best graded record, lowest position wins a tie; -1 when none
  function automatic int best_graded();
    int b;
    b = -1;
    for (int i = 0; i < tbl_count; i++)
      if (tbl_graded[i] && (b < 0 || tbl_grade[i] > tbl_grade[b])) b = i;
    return b;
  endfunction

  function automatic answer_t apply_op(logic [2:0] op, logic [KW-1:0] k, logic [6:0] pos,
                                       logic g, logic [GW-1:0] gr);
    answer_t a;
    int      i;
    a = '{ST_OK, '0, 1'b0, '0, '0};
    case (op)
      OP_INSERT: begin
        if (tbl_count >= DEPTH) a.status = ST_FULL;
        else begin
          i = tbl_count;
          while (i > 0 && !(k > tbl_key[i-1])) begin
            tbl_key[i] = tbl_key[i-1];
            tbl_grade[i] = tbl_grade[i-1];
            tbl_graded[i] = tbl_graded[i-1];
            i--;
          end
          store_rec(i, k, g, gr);
          tbl_count++;
        end
      end
      OP_REPK: begin
        i = search_key(k);
        if (i < 0) a.status = ST_ABSENT;
        else store_rec(i, k, g, gr);
      end
      OP_REPP: begin
        if (pos < 1 || pos > tbl_count) a.status = ST_BADPOS;
        else store_rec(pos - 1, k, g, gr);
      end
      OP_LOOKK, OP_LOOKP, OP_MAX: begin
        if (op == OP_LOOKK) begin
          i = search_key(k);
          if (i < 0) a.status = ST_ABSENT;
        end else if (op == OP_LOOKP) begin
          i = pos - 1;
          if (pos < 1 || pos > tbl_count) a.status = ST_BADPOS;
        end else begin
          i = best_graded();
          if (i < 0) a.status = ST_NOGRADE;
        end
        if (a.status == ST_OK) begin
          a.key    = tbl_key[i];
          a.graded = tbl_graded[i];
          a.grade  = tbl_grade[i];
        end
      end
      OP_DELETE: begin
        i = search_key(k);
        if (i < 0) a.status = ST_ABSENT;
        else begin
          for (int j = i; j + 1 < tbl_count; j++) begin
            tbl_key[j] = tbl_key[j+1];
            tbl_grade[j] = tbl_grade[j+1];
            tbl_graded[j] = tbl_graded[j+1];
          end
          tbl_count--;
        end
      end
      default: ;
    endcase
    a.count = tbl_count[6:0];
    return a;
  endfunction

  // send one item; valid stays high into the next call when it has no gap
  task automatic send_op(logic [2:0] op, logic [KW-1:0] k, logic [6:0] pos,
                         logic g, logic [GW-1:0] gr);
    int gap;
    gap = quiet_tx ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tuser  = op;
    s_axis_tdata  = {3'b0, gr, g, pos, k};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_answers.push_back(apply_op(op, k, pos, g, gr));
    @(negedge clk_i);
  endtask

  // sender holds off until every result has come back
  task automatic wait_all_answers();
    s_axis_tvalid = 1'b0;
    while (pending_answers.size() != 0) @(negedge clk_i);
  endtask

  // keys cluster in a small pool so hits and duplicates are common
  function automatic logic [KW-1:0] pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && tbl_count > 0) return tbl_key[$urandom_range(0, tbl_count - 1)];
    if (r < 90) return KW'($urandom_range(0, 120));
    return KW'($urandom);
  endfunction

  function automatic logic [GW-1:0] pick_grade();
    return ($urandom_range(0, 9) == 0) ? GW'($urandom) : GW'($urandom_range(0, 1000));
  endfunction

  function automatic logic [6:0] pick_pos();
    if ($urandom_range(0, 7) == 0 || tbl_count == 0) return 7'($urandom);
    return 7'($urandom_range(1, tbl_count));
  endfunction

  task automatic test_directed();
    send_op(OP_MAX, '0, 7'd0, 1'b0, '0);                  // empty table, no graded
    send_op(OP_LOOKP, '0, 7'd1, 1'b0, '0);                // bad position on empty
    send_op(OP_DELETE, 27'd5, 7'd0, 1'b0, '0);            // key absent
    send_op(OP_REPK, 27'd5, 7'd0, 1'b1, 10'd10);
    send_op(OP_LOOKK, 27'd5, 7'd0, 1'b0, '0);
    send_op(OP_INSERT, '1, 7'd0, 1'b1, '1);               // key and grade all ones
    send_op(OP_INSERT, '0, 7'd0, 1'b0, 10'd999);          // ungraded stores grade 0
    send_op(OP_INSERT, 27'd99999999, 7'd0, 1'b1, 10'd1000);
    send_op(OP_INSERT, 27'd50, 7'd0, 1'b1, 10'd1000);     // ties the grade of key 99999999
    send_op(OP_INSERT, 27'd50, 7'd0, 1'b1, 10'd3);        // duplicate key
    send_op(OP_MAX, '0, 7'd0, 1'b0, '0);
    send_op(OP_LOOKP, '0, 7'd5, 1'b0, '0);
    send_op(OP_LOOKP, '0, 7'd6, 1'b0, '0);                // past occupancy
    send_op(OP_LOOKP, '0, 7'd127, 1'b0, '0);
    send_op(OP_LOOKP, '0, 7'd0, 1'b0, '0);
    send_op(OP_REPP, 27'd7, 7'd1, 1'b1, 10'd1023);        // replaces the first record; its grade ties the max
    send_op(OP_LOOKK, 27'd50, 7'd0, 1'b0, '0);
    send_op(OP_REPK, 27'd50, 7'd0, 1'b0, 10'd77);
    send_op(OP_REPP, 27'd1, 7'd64, 1'b0, '0);
    send_op(OP_NOP, '1, 7'h7f, 1'b1, '1);
    send_op(OP_MAX, '0, 7'd0, 1'b0, '0);
    send_op(OP_DELETE, 27'd50, 7'd0, 1'b0, '0);
    send_op(OP_DELETE, '1, 7'd0, 1'b0, '0);
    send_op(OP_LOOKK, '0, 7'd0, 1'b0, '0);
  endtask

  // fill up to full, overflow once, query the max and position 64, then empty by deleting stored keys
  task automatic test_fill_and_drain();
    quiet_tx = 1'b1;
    while (tbl_count < DEPTH)
      send_op(OP_INSERT, pick_key(), '0, 1'($urandom_range(0, 1)), pick_grade());
    quiet_tx = 1'b0;
    send_op(OP_INSERT, pick_key(), '0, 1'b1, pick_grade());
    send_op(OP_MAX, '0, '0, 1'b0, '0);
    send_op(OP_LOOKP, '0, 7'd64, 1'b0, '0);
    send_op(OP_REPP, pick_key(), 7'd64, 1'b1, pick_grade());
    wait_all_answers();
    while (tbl_count > 0)
      send_op(OP_DELETE, tbl_key[$urandom_range(0, tbl_count - 1)], '0, 1'b0, '0);
    send_op(OP_MAX, '0, '0, 1'b0, '0);
  endtask

  // random mix; inserts lean toward the middle of the occupancy range
  task automatic test_random_mix();
    int          r;
    logic [2:0]  op;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 200 == 0) quiet_tx = ($urandom_range(0, 2) == 0);
      if (n % 300 == 150) drain_rx_stalls = ~drain_rx_stalls;
      r = $urandom_range(0, 99);
      if (r < ((tbl_count < 20) ? 40 : (tbl_count > 56 ? 12 : 22))) op = OP_INSERT;
      else if (r < 34) op = OP_DELETE;
      else if (r < 46) op = OP_REPK;
      else if (r < 58) op = OP_REPP;
      else if (r < 72) op = OP_LOOKK;
      else if (r < 84) op = OP_LOOKP;
      else if (r < 97) op = OP_MAX;
      else op = OP_NOP;
      send_op(op, pick_key(), pick_pos(), 1'($urandom_range(0, 1)), pick_grade());
    end
    quiet_tx = 1'b0;
    drain_rx_stalls = 1'b0;
  endtask

  // receiver stalls at random before each result, unless drain_rx_stalls is set
  always @(negedge clk_i) begin
    if (rx_took) begin
      rx_wait = drain_rx_stalls ? 0 : $urandom_range(0, 7);
      rx_took = 1'b0;
    end
    if (rx_wait > 0) begin
      m_axis_tready = 1'b0;
      rx_wait--;
    end else
      m_axis_tready = 1'b1;
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    answer_t want;
    answer_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      rx_took = 1'b1;
      got = '{m_axis_tuser, m_axis_tdata[26:0], m_axis_tdata[27],
              m_axis_tdata[37:28], m_axis_tdata[44:38]};
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item: %p", got);
      end else begin
        want = pending_answers.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    s_axis_tuser    = '0;
    m_axis_tready   = 1'b0;
    mismatches      = 0;
    cycles          = 0;
    tbl_count       = 0;
    rx_took         = 1'b0;
    rx_wait         = 0;
    drain_rx_stalls = 1'b0;
    quiet_tx        = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed();
    wait_all_answers();
    test_fill_and_drain();
    test_random_mix();
    test_fill_and_drain();

    wait_all_answers();
    repeat (2 * DEPTH) @(negedge clk_i);
    if (mismatches == 0 && pending_answers.size() == 0)
      $display("[sorted_key_table_with_max_core] OK");
    else
      $display("[sorted_key_table_with_max_core] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
src/skt_pkg.sv
src/skt_cell.sv
src/sorted_key_table_with_max_core.sv
tb/tb.sv
